>>> rtl/tiered_ring_smoothing_filter_top_assert.svh
// Assertion macros shared by the tiered ring smoothing filter RTL.
`ifndef TIERED_RING_SMOOTHING_FILTER_TOP_ASSERT_SVH
`define TIERED_RING_SMOOTHING_FILTER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TRSF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TRSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/trsf_pkg.sv
// Package with the types and constants of the tiered ring smoothing filter.
package trsf_pkg;

   localparam int RING_DEPTH_DEF = 16;
   localparam int DATA_W         = 32;
   localparam int THR_W          = 31;
   localparam int WIN_W          = 5;
   localparam int REM_W          = 32;
   localparam int FRAC_W         = 17;
   localparam int FRAC_STEPS     = 16;
   localparam int CSR_IDX_W      = 2;

   localparam logic [FRAC_W-1:0] FRAC_ONE   = 17'h10000;
   localparam logic [WIN_W-1:0]  WIN_RESET  = 5'd16;

   localparam logic [CSR_IDX_W-1:0] CSR_LOWER  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 2'd2;

   typedef struct packed {
      logic busy;
      logic done;
   } trsf_div_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FRAC,
      ST_FDIV,
      ST_SCALE,
      ST_WRITE,
      ST_SUM,
      ST_SDIV,
      ST_FINISH
   } trsf_state_type;

endpackage

>>> rtl/trsf_divider.sv
// Shared restoring divider, one quotient bit per cycle.
module trsf_divider
   import trsf_pkg::*;
#(
   parameter int QUO_W  = 36,
   parameter int STEP_W = $clog2(QUO_W + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [REM_W-1:0]       rem_init,
   input  logic [QUO_W-1:0]       quo_init,
   input  logic [REM_W-1:0]       divisor,
   input  logic [STEP_W-1:0]      steps,
   output trsf_div_stat_type      stat,
   output logic [QUO_W-1:0]       quotient
);

   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [REM_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [REM_W:0]    shifted;
   logic [REM_W:0]    diff;

   assign shifted = {rem_ff, quo_ff[QUO_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = rem_init;
         quo_in  = quo_init;
         dvs_in  = divisor;
         cnt_in  = steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[REM_W]) begin
            rem_in = diff[REM_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[REM_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

>>> rtl/trsf_ring.sv
// Sample ring memory with per-entry valid bits and a registered read port.
module trsf_ring
   import trsf_pkg::*;
#(
   parameter int DEPTH = RING_DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/tiered_ring_smoothing_filter_top.sv
// Top level of the tiered ring smoothing filter with its sequencer.
//
// Input words arrive on req_ (tuser = kind, tdata = signed Q16.16 sample).
// A clear word zeroes the ring and the write position and
// gives no result. A filter word gives one result word on rsp_ (tdata =
// smoothed value, tuser = saturation flag).
// A filter word passes the states FRAC, FDIV (only when the magnitude lies
// strictly between the thresholds), SCALE, WRITE, SUM, SDIV and FINISH,
// where SUM adds up the effective window of ring entries and SDIV divides
// the window sum, of 32 + log2(RING_DEPTH) bits, by the window length.
// One restoring divider is shared between the fraction and the window mean,
// and SUM reads the ring through its single read port.
// req_tready is high only while the sequencer is idle.
// The result sits in an output register; a stalled receiver lets the block
// take and work on the next word, which then waits before its last step.
// Reset empties the ring, sets the write position to zero and loads the
// register defaults (thresholds zero, window sixteen). Registers are to be
// written on csr_ only while the block is idle, which it does not enforce.
module tiered_ring_smoothing_filter_top
   import trsf_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DATA_W-1:0]    req_tdata,   // [31:0] sample_value
   input  logic                 req_tuser,   // [0] kind
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DATA_W-1:0]    rsp_tdata,   // [31:0] smoothed_value
   output logic                 rsp_tuser,   // [0] saturated
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   localparam int AW     = $clog2(RING_DEPTH);
   localparam int CW     = $clog2(RING_DEPTH + 1);
   localparam int SUM_W  = DATA_W + $clog2(RING_DEPTH);
   localparam int STEP_W = $clog2(SUM_W + 1);
   localparam int RES_W  = DATA_W + 2;

   trsf_state_type state_ff, state_in;

   logic [THR_W-1:0]        lower_ff, upper_ff;
   logic [WIN_W-1:0]        window_ff;
   logic [DATA_W-1:0]       v_ff, v_in;
   logic [DATA_W-1:0]       mag_ff, mag_in;
   logic [FRAC_W-1:0]       frac_ff, frac_in;
   logic [DATA_W-1:0]       part_ff, part_in;
   logic [DATA_W:0]         imm_ff, imm_in;
   logic [AW-1:0]           wpos_ff, wpos_in;
   logic [AW-1:0]           addr_ff, addr_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic                    issued_ff, issued_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [CW-1:0]           win_ff, win_in;
   logic [RES_W-1:0]        res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                    rsp_sat_ff, rsp_sat_in;

   logic                    div_start;
   logic [REM_W-1:0]        div_rem_init;
   logic [SUM_W-1:0]        div_quo_init;
   logic [REM_W-1:0]        div_divisor;
   logic [STEP_W-1:0]       div_steps;
   trsf_div_stat_type       div_stat;
   logic [SUM_W-1:0]        div_quotient;

   logic                    ring_clear;
   logic                    ring_wr_en;
   logic                    ring_rd_en;
   logic [DATA_W-1:0]       ring_rd_data;

   logic [2*DATA_W-16:0]    prod;
   logic [DATA_W:0]         s_val;
   logic [SUM_W-1:0]        sum_abs;
   logic [DATA_W:0]         q_signed;
   logic                    res_sat;
   logic                    out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign prod    = (2*DATA_W-15)'(mag_ff) * (2*DATA_W-15)'(FRAC_ONE - frac_ff);
   assign s_val   = v_ff[DATA_W-1] ? (-{1'b0, part_ff}) : {1'b0, part_ff};
   assign sum_abs = sum_ff[SUM_W-1] ? (-sum_ff) : sum_ff;
   assign q_signed = sum_ff[SUM_W-1] ? (-{1'b0, div_quotient[DATA_W-1:0]})
                                     : {1'b0, div_quotient[DATA_W-1:0]};
   assign res_sat = (res_ff[RES_W-1:DATA_W-1] != '0) && (res_ff[RES_W-1:DATA_W-1] != '1);

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff  <= '0;
         upper_ff  <= '0;
         window_ff <= WIN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LOWER:  lower_ff  <= csr_wdata[THR_W-1:0];
            CSR_UPPER:  upper_ff  <= csr_wdata[THR_W-1:0];
            CSR_WINDOW: window_ff <= csr_wdata[WIN_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      v_in         = v_ff;
      mag_in       = mag_ff;
      frac_in      = frac_ff;
      part_in      = part_ff;
      imm_in       = imm_ff;
      wpos_in      = wpos_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      issued_in    = 1'b0;
      sum_in       = sum_ff;
      win_in       = win_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_sat_in   = rsp_sat_ff;
      div_start    = 1'b0;
      div_rem_init = '0;
      div_quo_init = '0;
      div_divisor  = '0;
      div_steps    = '0;
      ring_clear   = 1'b0;
      ring_wr_en   = 1'b0;
      ring_rd_en   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser) begin
                  ring_clear = 1'b1;
                  wpos_in    = '0;
               end else begin
                  v_in     = req_tdata;
                  mag_in   = req_tdata[DATA_W-1] ? (~req_tdata + DATA_W'(1)) : req_tdata;
                  state_in = ST_FRAC;
                  if (window_ff == '0) begin
                     win_in = CW'(1);
                  end else if (32'(window_ff) > RING_DEPTH) begin
                     win_in = CW'(RING_DEPTH);
                  end else begin
                     win_in = CW'(window_ff);
                  end
               end
            end
         end
         ST_FRAC: begin
            state_in = ST_SCALE;
            if ((upper_ff <= lower_ff) || (mag_ff >= {1'b0, upper_ff})) begin
               frac_in = FRAC_ONE;
            end else if (mag_ff <= {1'b0, lower_ff}) begin
               frac_in = '0;
            end else begin
               div_start    = 1'b1;
               div_rem_init = mag_ff - {1'b0, lower_ff};
               div_divisor  = {1'b0, upper_ff - lower_ff};
               div_steps    = STEP_W'(FRAC_STEPS);
               state_in     = ST_FDIV;
            end
         end
         ST_FDIV: begin
            if (div_stat.done) begin
               frac_in  = {1'b0, div_quotient[FRAC_STEPS-1:0]};
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            part_in  = prod[2*DATA_W-1-16:16];
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            imm_in     = {v_ff[DATA_W-1], v_ff} - s_val;
            wpos_in    = (wpos_ff == '0) ? AW'(RING_DEPTH - 1) : (wpos_ff - AW'(1));
            ring_wr_en = 1'b1;
            addr_in    = wpos_in;
            cnt_in     = '0;
            sum_in     = '0;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            if (cnt_ff < win_ff) begin
               ring_rd_en = 1'b1;
               issued_in  = 1'b1;
               cnt_in     = cnt_ff + CW'(1);
               addr_in    = (addr_ff == AW'(RING_DEPTH - 1)) ? '0 : (addr_ff + AW'(1));
            end
            if (issued_ff) begin
               sum_in = sum_ff + {{(SUM_W-DATA_W){ring_rd_data[DATA_W-1]}}, ring_rd_data};
            end else if (cnt_ff == win_ff) begin
               div_start    = 1'b1;
               div_quo_init = sum_abs;
               div_divisor  = REM_W'(win_ff);
               div_steps    = STEP_W'(SUM_W);
               state_in     = ST_SDIV;
            end
         end
         ST_SDIV: begin
            if (div_stat.done) begin
               res_in   = {q_signed[DATA_W], q_signed} + {imm_ff[DATA_W], imm_ff};
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sat_in   = res_sat;
               if (!res_sat) begin
                  rsp_data_in = res_ff[DATA_W-1:0];
               end else if (res_ff[RES_W-1]) begin
                  rsp_data_in = {1'b1, {(DATA_W-1){1'b0}}};
               end else begin
                  rsp_data_in = {1'b0, {(DATA_W-1){1'b1}}};
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wpos_ff      <= '0;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wpos_ff      <= wpos_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      v_ff        <= v_in;
      mag_ff      <= mag_in;
      frac_ff     <= frac_in;
      part_ff     <= part_in;
      imm_ff      <= imm_in;
      addr_ff     <= addr_in;
      cnt_ff      <= cnt_in;
      sum_ff      <= sum_in;
      win_ff      <= win_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   trsf_divider #(
      .QUO_W  (SUM_W),
      .STEP_W (STEP_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (div_rem_init),
      .quo_init (div_quo_init),
      .divisor  (div_divisor),
      .steps    (div_steps),
      .stat     (div_stat),
      .quotient (div_quotient)
   );

   trsf_ring #(
      .DEPTH (RING_DEPTH),
      .AW    (AW)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .clear   (ring_clear),
      .wr_en   (ring_wr_en),
      .wr_addr (wpos_in),
      .wr_data (s_val[DATA_W-1:0]),
      .rd_en   (ring_rd_en),
      .rd_addr (addr_ff),
      .rd_data (ring_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

`include "tiered_ring_smoothing_filter_top_assert.svh"

   `TRSF_ASSERT_NEXT(a_busy_after_sample, clock, reset, req_tvalid && req_tready && !req_tuser, !req_tready, "sequencer still ready after a sample word")
   `TRSF_ASSERT_SAME(a_div_start_idle, clock, reset, div_start, !div_stat.busy, "divider started while busy")
   `TRSF_ASSERT_SAME(a_div_done_waited, clock, reset, div_stat.done, state_ff == ST_FDIV || state_ff == ST_SDIV, "divider finished with nobody waiting")
   `TRSF_ASSERT_SAME(a_sat_clipped, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == 32'h7FFF_FFFF || rsp_tdata == 32'h8000_0000, "saturated word not at a range limit")

endmodule

>>> tb/tiered_ring_smoothing_filter_top_test.sv
// Self-checking testbench of the tiered ring smoothing filter, directed table then random words.
module tiered_ring_smoothing_filter_top_test
   import trsf_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int     HALF_PERIOD  = 6;
   localparam int     RESET_CYCLES = 10;
   localparam int     SETTLE       = 100;
   localparam int     CYCLE_LIMIT  = 1000000;
   localparam int     SEGMENT_LEN  = 112;
   localparam int     MAX_PRINTS   = 60;
   localparam longint SAT_HI       = 64'sd2147483647;
   localparam longint SAT_LO       = -64'sd2147483648;

   localparam logic KIND_FILTER = 1'b0;
   localparam logic KIND_CLEAR  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam int SEND_IDLE_PCT[4]  = '{0, 45, 0, 9};
   localparam int RECV_STALL_PCT[4] = '{0, 0, 45, 9};

   typedef enum logic {
      ROW_WORD,
      ROW_CSR
   } row_op_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              sat;
   } smoothed_word_type;

   typedef struct packed {
      row_op_type           op;
      logic [CSR_IDX_W-1:0] index;
      logic                 kind;
      logic [DATA_W-1:0]    data;
      logic                 typed;
      logic [DATA_W-1:0]    want_value;
      logic                 want_sat;
   } row_type;

   localparam int NUM_ROWS = 34;
   localparam row_type DIRECTED_ROWS[NUM_ROWS] = '{
      '{ROW_WORD, CSR_LOWER,  KIND_FILTER, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0},
      '{ROW_WORD, CSR_LOWER,  KIND_FILTER, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0},
      '{ROW_WORD, CSR_LOWER,  KIND_FILTER, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
      '{ROW_WORD, CSR_LOWER,  KIND_FILTER, 32'h0000_0001, 1'b1, 32'h0000_0001, 1'b0},
      '{ROW_WORD, CSR_LOWER,  KIND_FILTER, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{ROW_WORD, CSR_LOWER,  KIND_CLEAR,  32'hFFFF_FFFF, 1'b0, 32'h0,         1'b0},
      '{ROW_CSR,  CSR_LOWER,  KIND_FILTER, 32'h0001_0000, 1'b0, 32'h0,         1'b0},
      '{ROW_CSR,  CSR_UPPER,  KIND_FILTER, 32'h0003_0000, 1'b0, 32'h0,         1'b0},
      '{ROW_CSR,  CSR_WINDOW, KIND_FILTER, 32'hFFFF_FFE4, 1'b0, 32'h0,         1'b0},
      '{ROW_WORD, CSR_LOWER,  KIND_FILTER, 32'h0000_8000, 1'b0, 32'h0,         1'b0},
      '{ROW_WORD, CSR_LOWER,  KIND_FILTER, 32'h0002_0000, 1'b0, 32'h0,         1'b0},
      '{ROW_WORD, CSR_LOWER,  KIND_FILTER, 32'hFFFE_0000, 1'b0, 32'h0,         1'b0},
      '{ROW_WORD, CSR_LOWER,  KIND_FILTER, 32'h0003_0000, 1'b0, 32'h0,         1'b0},
      '{ROW_WORD, CSR_LOWER,  KIND_FILTER, 32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0},
      '{ROW_WORD, CSR_LOWER,  KIND_FILTER, 32'h0001_0000, 1'b0, 32'h0,         1'b0},
      '{ROW_CSR,  CSR_WINDOW, KIND_FILTER, 32'h0000_0000, 1'b0, 32'h0,         1'b0},
      '{ROW_WORD, CSR_LOWER,  KIND_FILTER, 32'h1234_5678, 1'b0, 32'h0,         1'b0},
      '{ROW_CSR,  CSR_WINDOW, KIND_FILTER, 32'h0000_001F, 1'b0, 32'h0,         1'b0},
      '{ROW_WORD, CSR_LOWER,  KIND_FILTER, 32'hEDCB_A988, 1'b0, 32'h0,         1'b0},
      '{ROW_CSR,  CSR_UPPER,  KIND_FILTER, 32'h0000_8000, 1'b0, 32'h0,         1'b0},
      '{ROW_WORD, CSR_LOWER,  KIND_FILTER, 32'h0005_4321, 1'b0, 32'h0,         1'b0},
      '{ROW_CSR,  CSR_LOWER,  KIND_FILTER, 32'h4000_0000, 1'b0, 32'h0,         1'b0},
      '{ROW_CSR,  CSR_UPPER,  KIND_FILTER, 32'h4000_0001, 1'b0, 32'h0,         1'b0},
      '{ROW_CSR,  CSR_WINDOW, KIND_FILTER, 32'h0000_0002, 1'b0, 32'h0,         1'b0},
      '{ROW_WORD, CSR_LOWER,  KIND_CLEAR,  32'h0000_0000, 1'b0, 32'h0,         1'b0},
      '{ROW_WORD, CSR_LOWER,  KIND_FILTER, 32'h3FFF_FFFF, 1'b0, 32'h0,         1'b0},
      '{ROW_WORD, CSR_LOWER,  KIND_FILTER, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b1},
      '{ROW_WORD, CSR_LOWER,  KIND_CLEAR,  32'h5A5A_A5A5, 1'b0, 32'h0,         1'b0},
      '{ROW_WORD, CSR_LOWER,  KIND_FILTER, 32'hC000_0000, 1'b0, 32'h0,         1'b0},
      '{ROW_WORD, CSR_LOWER,  KIND_FILTER, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b1},
      '{ROW_CSR,  CSR_UNUSED, KIND_FILTER, 32'hFFFF_FFFF, 1'b0, 32'h0,         1'b0},
      '{ROW_CSR,  CSR_UPPER,  KIND_FILTER, 32'hFFFF_FFFF, 1'b0, 32'h0,         1'b0},
      '{ROW_WORD, CSR_LOWER,  KIND_FILTER, 32'h6000_0000, 1'b0, 32'h0,         1'b0},
      '{ROW_WORD, CSR_LOWER,  KIND_FILTER, 32'h8000_0000, 1'b0, 32'h0,         1'b0}
   };

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [DATA_W-1:0]    req_tdata;
   logic                 req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [DATA_W-1:0]    rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0]    csr_wdata;

   logic signed [DATA_W-1:0] tap_ring [RING_DEPTH_DEF];
   int                       tap_pos;
   logic [THR_W-1:0]         lower_thr;
   logic [THR_W-1:0]         upper_thr;
   logic [WIN_W-1:0]         win_len;
   smoothed_word_type        smoothed_due[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int stall_left = 0;
   int error_count = 0;
   int cycle_count = 0;

   tiered_ring_smoothing_filter_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic void clear_taps();
      for (int k = 0; k < RING_DEPTH_DEF; k++) begin
         tap_ring[k] = '0;
      end
      tap_pos = 0;
   endfunction

   function automatic smoothed_word_type filter_sample(input logic [DATA_W-1:0] raw);
      longint            v, mag, lo, hi, frac, part, s, sum, res;
      int                span;
      smoothed_word_type word;
      v = longint'($signed(raw));
      mag = (v < 0) ? -v : v;
      lo = longint'(lower_thr);
      hi = longint'(upper_thr);
      if (hi <= lo) begin
         frac = longint'(FRAC_ONE);
      end else if (mag <= lo) begin
         frac = 0;
      end else begin
         frac = ((mag - lo) <<< 16) / (hi - lo);
         if (frac > longint'(FRAC_ONE)) begin
            frac = longint'(FRAC_ONE);
         end
      end
      part = (mag * (longint'(FRAC_ONE) - frac)) >>> 16;
      s = (v < 0) ? -part : part;
      tap_pos = (tap_pos == 0) ? RING_DEPTH_DEF - 1 : tap_pos - 1;
      tap_ring[tap_pos] = s[DATA_W-1:0];
      span = int'(win_len);
      if (span == 0) begin
         span = 1;
      end
      if (span > RING_DEPTH_DEF) begin
         span = RING_DEPTH_DEF;
      end
      sum = 0;
      for (int k = 0; k < span; k++) begin
         sum += longint'(tap_ring[(tap_pos + k) % RING_DEPTH_DEF]);
      end
      res = sum / span + (v - s);
      word.sat = 1'b0;
      if (res > SAT_HI) begin
         res = SAT_HI;
         word.sat = 1'b1;
      end else if (res < SAT_LO) begin
         res = SAT_LO;
         word.sat = 1'b1;
      end
      word.value = res[DATA_W-1:0];
      return word;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTS) begin
         $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      end
   endtask

   task automatic send_word(input logic kind, input logic [DATA_W-1:0] data,
                            input logic typed, input smoothed_word_type typed_word);
      smoothed_word_type due;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 70)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      if (kind == KIND_CLEAR) begin
         clear_taps();
      end else begin
         due = filter_sample(data);
         smoothed_due.insert(smoothed_due.size(), typed ? typed_word : due);
      end
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [DATA_W-1:0] wdata);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= wdata;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_LOWER:  lower_thr = wdata[THR_W-1:0];
         CSR_UPPER:  upper_thr = wdata[THR_W-1:0];
         CSR_WINDOW: win_len = wdata[WIN_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (smoothed_due.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic configure_segment(input int setting);
      logic [THR_W-1:0] lo, hi;
      logic [WIN_W-1:0] win;
      case (setting)
         0: begin lo = '0;            hi = 31'h7FFF_FFFF; win = 5'd16; end
         1: begin lo = 31'h7FFF_FFFE; hi = 31'h7FFF_FFFF; win = 5'd1;  end
         2: begin lo = '0;            hi = 31'd1;         win = 5'd31; end
         3: begin lo = 31'h7FFF_FFFF; hi = '0;            win = 5'd0;  end
         default: begin
            case ($urandom_range(3))
               0: begin
                  lo = THR_W'($urandom_range(0, 32'h7FFF_FFFF));
                  hi = THR_W'($urandom_range(0, 32'h7FFF_FFFF));
               end
               1: begin
                  lo = THR_W'($urandom_range(0, 32'h0002_0000));
                  hi = THR_W'(lo + $urandom_range(1, 32'h0008_0000));
               end
               2: begin
                  lo = THR_W'($urandom_range(0, 32'h7FFF_FFFF));
                  hi = THR_W'($urandom_range(0, lo));
               end
               default: begin
                  lo = THR_W'($urandom_range(0, 32'h4000_0000));
                  hi = THR_W'(lo + $urandom_range(1, 32'h3FFF_FFFF));
               end
            endcase
            case ($urandom_range(7))
               0: win = 5'd0;
               1: win = 5'd1;
               2: win = 5'd16;
               3: win = 5'd17;
               4: win = 5'd31;
               default: win = WIN_W'($urandom_range(1, 16));
            endcase
         end
      endcase
      wait_idle();
      write_reg(CSR_LOWER, {1'($urandom_range(1)), lo});
      write_reg(CSR_UPPER, {1'($urandom_range(1)), hi});
      write_reg(CSR_WINDOW, ($urandom() & ~32'h1F) | DATA_W'(win));
      if ($urandom_range(3) == 0) begin
         write_reg(CSR_UNUSED, $urandom());
      end
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(99) < recv_stall_pct) begin
         stall_left <= ($urandom_range(19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_result
      smoothed_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (smoothed_due.size() == 0) begin
            report_mismatch($sformatf("result word %h/%b with nothing expected",
                                      rsp_tdata, rsp_tuser));
         end else begin
            want = smoothed_due.pop_front();
            if (rsp_tdata !== want.value) begin
               report_mismatch($sformatf("smoothed_value %h, expected %h",
                                         rsp_tdata, want.value));
            end
            if (rsp_tuser !== want.sat) begin
               report_mismatch($sformatf("saturated %b, expected %b", rsp_tuser, want.sat));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      row_type          row;
      logic [DATA_W-1:0] mag, data, span_lo, span_hi;
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = KIND_FILTER;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = CSR_LOWER;
      csr_wdata  = '0;
      clear_taps();
      lower_thr = '0;
      upper_thr = '0;
      win_len   = WIN_RESET;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < NUM_ROWS; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.op == ROW_CSR) begin
            wait_idle();
            write_reg(row.index, row.data);
         end else begin
            send_word(row.kind, row.data, row.typed, {row.want_value, row.want_sat});
         end
      end

      for (int phase = 0; phase < 4; phase++) begin
         for (int seg = 0; seg < 3; seg++) begin
            configure_segment(phase * 3 + seg);
            send_idle_pct  = SEND_IDLE_PCT[phase];
            recv_stall_pct = RECV_STALL_PCT[phase];
            for (int n = 0; n < SEGMENT_LEN; n++) begin
               if ($urandom_range(99) < 4) begin
                  send_word(KIND_CLEAR, $urandom(), 1'b0, '0);
               end else begin
                  case ($urandom_range(9))
                     0, 1, 2, 3, 4: begin
                        span_lo = (lower_thr < upper_thr) ? DATA_W'(lower_thr) : DATA_W'(upper_thr);
                        span_hi = (lower_thr < upper_thr) ? DATA_W'(upper_thr) : DATA_W'(lower_thr);
                        mag  = $urandom_range(span_lo, span_hi + 1);
                        data = $urandom_range(1) ? -mag : mag;
                     end
                     7: begin
                        mag  = $urandom_range(0, 32'h0003_FFFF);
                        data = $urandom_range(1) ? -mag : mag;
                     end
                     8: begin
                        case ($urandom_range(4))
                           0: data = 32'h7FFF_FFFF;
                           1: data = 32'h8000_0000;
                           2: data = 32'h0000_0000;
                           3: data = 32'h0000_0001;
                           default: data = 32'hFFFF_FFFF;
                        endcase
                     end
                     default: data = $urandom();
                  endcase
                  send_word(KIND_FILTER, data, 1'b0, '0);
               end
            end
         end
      end

      wait_idle();
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/trsf_pkg.sv
rtl/trsf_divider.sv
rtl/trsf_ring.sv
rtl/tiered_ring_smoothing_filter_top.sv
tb/tiered_ring_smoothing_filter_top_test.sv
